@@ design/pbe_pkg.sv @@
// Shared types and constants of the PackBits row encoder.
package pbe_pkg;

    // Widths fixed by the block's fields and state
    localparam int BYTE_W      = 8;
    localparam int FILL_W      = 9;
    localparam int BLK_IDX_W   = 7;
    localparam int LEN_W       = 16;
    localparam int WORD_BYTES  = 8;
    localparam int WORD_W      = WORD_BYTES * BYTE_W;
    localparam int LANE_W      = 3;
    localparam int COUNT_W     = 4;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Kind of block to write out
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_LIT,
        EMIT_RUN
    } emit_kind_t;

    // One block: header byte, and the value byte for a run
    typedef struct packed {
        emit_kind_t        kind;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] val;
    } emit_t;

    // One request: store write, first block, store restart, row-end block
    typedef struct packed {
        logic                 wr_en;
        logic [BLK_IDX_W-1:0] wr_addr;
        logic [BYTE_W-1:0]    data;
        emit_t                emit_a;
        logic                 post_wr;
        emit_t                emit_b;
        logic                 row_end;
        logic [LEN_W-1:0]     row_length;
    } cmd_t;

endpackage

@@ design/pbe_front.sv @@
// Front end: tracks run/literal state per byte and issues one request per byte.
module pbe_front #(
    parameter int MAX_LITERAL = 128,
    parameter int MAX_RUN_LEN = 128,
    parameter int MIN_RUN_LEN = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pbe_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_row_end,
    output logic                         push_valid,
    input  logic                         push_ready,
    output pbe_pkg::cmd_t                push_cmd
);

    localparam logic [pbe_pkg::FILL_W-1:0] MAX_LIT_F = MAX_LITERAL[pbe_pkg::FILL_W-1:0];
    localparam logic [pbe_pkg::FILL_W-1:0] MAX_RUN_F = MAX_RUN_LEN[pbe_pkg::FILL_W-1:0];
    localparam logic [pbe_pkg::FILL_W-1:0] MIN_RUN_F = MIN_RUN_LEN[pbe_pkg::FILL_W-1:0];

    logic [pbe_pkg::FILL_W-1:0] fill_reg, fill_next, fill_mid;
    logic [pbe_pkg::BYTE_W-1:0] rb_reg, rb_next, rb_mid;
    logic [pbe_pkg::BYTE_W-1:0] prev_reg, prev_next;
    logic                       mode_reg, mode_next, mode_mid;
    logic                       active_reg, active_next;
    logic [pbe_pkg::LEN_W-1:0]  total_reg, total_next, total_sat;

    logic [pbe_pkg::FILL_W-1:0] n;
    logic [pbe_pkg::FILL_W-1:0] rb_wide;
    logic [pbe_pkg::FILL_W-1:0] run_cnt_a;
    logic [pbe_pkg::FILL_W-1:0] run_cnt_b;
    logic [pbe_pkg::FILL_W-1:0] add_a, add_b;
    logic [pbe_pkg::LEN_W:0]    sum;
    logic                       accept;
    pbe_pkg::emit_t             emit_a, emit_b;
    logic                       post_wr;
    logic                       wr_en;
    logic [pbe_pkg::BLK_IDX_W-1:0] wr_addr;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    assign n         = fill_reg + 9'd1;
    assign rb_wide   = {1'b0, rb_reg};
    assign run_cnt_a = n - 9'd1 - rb_wide;

    // Classify the byte: store write, block to close, new mode
    always_comb begin
        emit_a      = '{kind: pbe_pkg::EMIT_NONE, hdr: '0, val: in_byte};
        post_wr     = 1'b0;
        fill_mid    = fill_reg;
        rb_mid      = rb_reg;
        mode_mid    = mode_reg;
        wr_en       = 1'b0;
        wr_addr     = fill_reg[pbe_pkg::BLK_IDX_W-1:0];
        if (!active_reg) begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            fill_mid = 9'd1;
            rb_mid   = '0;
            mode_mid = 1'b0;
        end else begin
            wr_en    = (fill_reg < MAX_LIT_F);
            fill_mid = n;
            if (!mode_reg) begin
                priority if (n > MAX_LIT_F) begin
                    // Literal block is full: close it and restart with this byte
                    emit_a.kind = pbe_pkg::EMIT_LIT;
                    emit_a.hdr  = 8'(n - 9'd2);
                    post_wr     = 1'b1;
                    fill_mid    = 9'd1;
                    rb_mid      = '0;
                end else if (in_byte == prev_reg) begin
                    if ((n - rb_wide) >= MIN_RUN_F) begin
                        // Close the literal part before the run
                        if (rb_reg != '0) begin
                            emit_a.kind = pbe_pkg::EMIT_LIT;
                            emit_a.hdr  = rb_reg - 8'd1;
                        end
                        mode_mid = 1'b1;
                    end else if (rb_reg == '0) begin
                        mode_mid = 1'b1;
                    end
                end else begin
                    rb_mid = 8'(n - 9'd1);
                end
            end else if (in_byte != prev_reg || (n - rb_wide) > MAX_RUN_F) begin
                // Run broken or full: close it and restart with this byte
                emit_a.kind = pbe_pkg::EMIT_RUN;
                emit_a.hdr  = 8'd1 - run_cnt_a[pbe_pkg::BYTE_W-1:0];
                emit_a.val  = prev_reg;
                post_wr     = 1'b1;
                fill_mid    = 9'd1;
                rb_mid      = '0;
                mode_mid    = 1'b0;
            end
        end
    end

    assign run_cnt_b = fill_mid - {1'b0, rb_mid};

    // Flush at row end
    always_comb begin
        emit_b = '{kind: pbe_pkg::EMIT_NONE, hdr: '0, val: in_byte};
        if (in_row_end) begin
            if (mode_mid) begin
                emit_b.kind = pbe_pkg::EMIT_RUN;
                emit_b.hdr  = 8'd1 - run_cnt_b[pbe_pkg::BYTE_W-1:0];
            end else begin
                emit_b.kind = pbe_pkg::EMIT_LIT;
                emit_b.hdr  = 8'(fill_mid - 9'd1);
            end
        end
    end

    // Count compressed bytes of the row, saturating
    always_comb begin
        unique case (emit_a.kind)
            pbe_pkg::EMIT_LIT: add_a = {1'b0, emit_a.hdr} + 9'd2;
            pbe_pkg::EMIT_RUN: add_a = 9'd2;
            default:           add_a = '0;
        endcase
        unique case (emit_b.kind)
            pbe_pkg::EMIT_LIT: add_b = {1'b0, emit_b.hdr} + 9'd2;
            pbe_pkg::EMIT_RUN: add_b = 9'd2;
            default:           add_b = '0;
        endcase
        sum       = {1'b0, (active_reg ? total_reg : 16'd0)} + 17'(add_a) + 17'(add_b);
        total_sat = sum[pbe_pkg::LEN_W] ? 16'hFFFF : sum[pbe_pkg::LEN_W-1:0];
    end

    // Build the request
    always_comb begin
        push_cmd.wr_en      = wr_en;
        push_cmd.wr_addr    = wr_addr;
        push_cmd.data       = in_byte;
        push_cmd.emit_a     = emit_a;
        push_cmd.post_wr    = post_wr;
        push_cmd.emit_b     = emit_b;
        push_cmd.row_end    = in_row_end;
        push_cmd.row_length = total_sat;
    end

    // Advance state on each accepted byte; clear it at row end
    always_comb begin
        fill_next   = fill_reg;
        rb_next     = rb_reg;
        prev_next   = prev_reg;
        mode_next   = mode_reg;
        active_next = active_reg;
        total_next  = total_reg;
        if (accept) begin
            if (in_row_end) begin
                fill_next   = '0;
                rb_next     = '0;
                prev_next   = '0;
                mode_next   = 1'b0;
                active_next = 1'b0;
                total_next  = '0;
            end else begin
                fill_next   = fill_mid;
                rb_next     = rb_mid;
                prev_next   = in_byte;
                mode_next   = mode_mid;
                active_next = 1'b1;
                total_next  = total_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            rb_reg     <= '0;
            prev_reg   <= '0;
            mode_reg   <= 1'b0;
            active_reg <= 1'b0;
            total_reg  <= '0;
        end else begin
            fill_reg   <= fill_next;
            rb_reg     <= rb_next;
            prev_reg   <= prev_next;
            mode_reg   <= mode_next;
            active_reg <= active_next;
            total_reg  <= total_next;
        end
    end

endmodule

@@ design/pbe_queue.sv @@
// Request queue between the front end and the back end.
module pbe_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  pbe_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pbe_pkg::cmd_t pop_cmd
);

    localparam logic [pbe_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        pbe_pkg::QUEUE_DEPTH[pbe_pkg::QUEUE_CNT_W-1:0];

    pbe_pkg::cmd_t                    entry_reg [pbe_pkg::QUEUE_DEPTH];
    logic [pbe_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pbe_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pbe_pkg::QUEUE_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Move pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 3'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold request payloads
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/pbe_back.sv @@
// Back end: literal store, byte sequencer, word packer and output register.
module pbe_back #(
    parameter int MAX_LITERAL = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  pbe_pkg::cmd_t                 q_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pbe_pkg::WORD_W-1:0]    m_packed_bytes,
    output logic [pbe_pkg::COUNT_W-1:0]   m_byte_count,
    output logic                          m_last_of_item,
    output logic                          m_row_done,
    output logic [pbe_pkg::LEN_W-1:0]     m_row_length
);

    localparam int AW = $clog2(MAX_LITERAL);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    // Literal store
    logic [pbe_pkg::BYTE_W-1:0] store_mem [MAX_LITERAL];
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr;
    logic [pbe_pkg::BYTE_W-1:0] mem_wdata;
    logic [pbe_pkg::BYTE_W-1:0] rdata_reg;

    // Sequencer
    logic [1:0]                    phase_reg, phase_next;
    logic                          second_reg, second_next;
    logic [pbe_pkg::BLK_IDX_W-1:0] idx_reg, idx_next;
    pbe_pkg::cmd_t                 cur_reg, cur_next;
    pbe_pkg::emit_t                emit_cur;
    logic                          has_b;
    logic                          step, step_mem, step_end, step_last;
    logic [pbe_pkg::BYTE_W-1:0]    step_byte;
    logic                          adv;

    // Byte stage
    logic                       s1_valid_reg;
    logic                       s1_mem_reg;
    logic [pbe_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                       s1_last_reg;
    logic                       s1_done_reg;
    logic [pbe_pkg::LEN_W-1:0]  s1_len_reg;

    // Packer and output
    logic [pbe_pkg::LANE_W-1:0] pk_cnt_reg;
    logic [pbe_pkg::WORD_W-1:0] pk_word_reg;
    logic [pbe_pkg::WORD_W-1:0] word_ins;
    logic [pbe_pkg::BYTE_W-1:0] pk_byte;
    logic                       word_done, out_free, pk_take;
    logic                       m_valid_reg;
    logic [pbe_pkg::WORD_W-1:0]  m_word_reg;
    logic [pbe_pkg::COUNT_W-1:0] m_count_reg;
    logic                        m_last_reg;
    logic                        m_done_reg;
    logic [pbe_pkg::LEN_W-1:0]   m_len_reg;

    assign emit_cur  = second_reg ? cur_reg.emit_b : cur_reg.emit_a;
    assign has_b     = (cur_reg.emit_b.kind != pbe_pkg::EMIT_NONE);
    assign step_last = step_end && (second_reg || !has_b);

    // Step through requests: pop, header, value or stored bytes
    always_comb begin
        q_ready     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = cur_reg.data;
        phase_next  = phase_reg;
        second_next = second_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        step        = 1'b0;
        step_mem    = 1'b0;
        step_end    = 1'b0;
        step_byte   = emit_cur.hdr;
        unique case (phase_reg)
            PH_IDLE: begin
                if (q_valid) begin
                    q_ready   = 1'b1;
                    cur_next  = q_cmd;
                    mem_we    = q_cmd.wr_en;
                    mem_waddr = q_cmd.wr_addr[AW-1:0];
                    mem_wdata = q_cmd.data;
                    if (q_cmd.emit_a.kind != pbe_pkg::EMIT_NONE) begin
                        phase_next  = PH_HDR;
                        second_next = 1'b0;
                    end else if (q_cmd.emit_b.kind != pbe_pkg::EMIT_NONE) begin
                        phase_next  = PH_HDR;
                        second_next = 1'b1;
                    end
                end
            end
            PH_HDR: begin
                if (adv) begin
                    step       = 1'b1;
                    idx_next   = '0;
                    phase_next = (emit_cur.kind == pbe_pkg::EMIT_LIT) ? PH_BODY : PH_VAL;
                end
            end
            PH_VAL: begin
                if (adv) begin
                    step      = 1'b1;
                    step_byte = emit_cur.val;
                    step_end  = 1'b1;
                end
            end
            PH_BODY: begin
                if (adv) begin
                    step     = 1'b1;
                    step_mem = 1'b1;
                    mem_re   = 1'b1;
                    idx_next = idx_reg + 7'd1;
                    step_end = (idx_reg == emit_cur.hdr[pbe_pkg::BLK_IDX_W-1:0]);
                end
            end
        endcase
        // End of a block: restart the store, then the row-end block or idle
        if (step_end) begin
            if (!second_reg && cur_reg.post_wr) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = cur_reg.data;
            end
            if (!second_reg && has_b) begin
                phase_next  = PH_HDR;
                second_next = 1'b1;
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= store_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            second_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
    end

    // Byte stage: hold while the packer stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && step) begin
            s1_mem_reg  <= step_mem;
            s1_byte_reg <= step_byte;
            s1_last_reg <= step_last;
            s1_done_reg <= step_last && cur_reg.row_end;
            s1_len_reg  <= cur_reg.row_length;
        end
    end

    // Pack bytes into a word, first byte low
    always_comb begin
        pk_byte  = s1_mem_reg ? rdata_reg : s1_byte_reg;
        word_ins = (pk_cnt_reg == '0) ? '0 : pk_word_reg;
        word_ins[{pk_cnt_reg, 3'b000} +: pbe_pkg::BYTE_W] = pk_byte;
    end

    assign word_done = (pk_cnt_reg == 3'd7) || s1_last_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign pk_take   = s1_valid_reg && (!word_done || out_free);
    assign adv       = !s1_valid_reg || pk_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pk_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pk_take) begin
                pk_cnt_reg <= word_done ? 3'd0 : pk_cnt_reg + 3'd1;
            end
            if (pk_take && word_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pk_take && !word_done) begin
            pk_word_reg <= word_ins;
        end
        if (pk_take && word_done) begin
            m_word_reg  <= word_ins;
            m_count_reg <= {1'b0, pk_cnt_reg} + 4'd1;
            m_last_reg  <= s1_last_reg;
            m_done_reg  <= s1_done_reg;
            m_len_reg   <= s1_done_reg ? s1_len_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_packed_bytes = m_word_reg;
    assign m_byte_count   = m_count_reg;
    assign m_last_of_item = m_last_reg;
    assign m_row_done     = m_done_reg;
    assign m_row_length   = m_len_reg;

endmodule

@@ design/packbits_row_encoder.sv @@
// Top level of the PackBits row encoder: front end, request queue, back end.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_data_byte, s_row_end
//   m_        out        m_valid / m_ready   m_packed_bytes, m_byte_count,
//                                            m_last_of_item, m_row_done, m_row_length
//
// The front end takes one byte per cycle while the four-entry request queue has room.
// The back end pops each request, then sends its blocks byte by byte: a literal block
// as its header and stored bytes, a run as its header and value, with stored bytes read
// through the single store read port; it pops the next request only once these are out.
// Reset is synchronous; the literal store needs no clearing, so the block is ready
// as soon as reset is released. m_ready low stalls the packer, then the queue, then s_ready.
module packbits_row_encoder #(
    parameter int MAX_LITERAL = 128,
    parameter int MAX_RUN_LEN = 128,
    parameter int MIN_RUN_LEN = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pbe_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                          s_row_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pbe_pkg::WORD_W-1:0]    m_packed_bytes,
    output logic [pbe_pkg::COUNT_W-1:0]   m_byte_count,
    output logic                          m_last_of_item,
    output logic                          m_row_done,
    output logic [pbe_pkg::LEN_W-1:0]     m_row_length
);

    logic          push_valid, push_ready;
    pbe_pkg::cmd_t push_cmd;
    logic          pop_valid, pop_ready;
    pbe_pkg::cmd_t pop_cmd;

    // Classify bytes into requests
    pbe_front #(
        .MAX_LITERAL (MAX_LITERAL),
        .MAX_RUN_LEN (MAX_RUN_LEN),
        .MIN_RUN_LEN (MIN_RUN_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_data_byte),
        .in_row_end (s_row_end),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Buffer requests
    pbe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Carry out requests and pack output words
    pbe_back #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_cmd          (pop_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_bytes (m_packed_bytes),
        .m_byte_count   (m_byte_count),
        .m_last_of_item (m_last_of_item),
        .m_row_done     (m_row_done),
        .m_row_length   (m_row_length)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the PackBits row encoder with random source gaps and sink stalls.
module testbench;

    localparam int BYTE_W     = pbe_pkg::BYTE_W;
    localparam int FILL_W     = pbe_pkg::FILL_W;
    localparam int LEN_W      = pbe_pkg::LEN_W;
    localparam int WORD_BYTES = pbe_pkg::WORD_BYTES;
    localparam int WORD_W     = pbe_pkg::WORD_W;
    localparam int COUNT_W    = pbe_pkg::COUNT_W;

    // Input request: one row byte and its row-end flag
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              row_end;
    } row_byte_t;

    // One packed output word as the encoder should present it
    typedef struct packed {
        logic [WORD_W-1:0]  packed_bytes;
        logic [COUNT_W-1:0] byte_count;
        logic               last_of_item;
        logic               row_done;
        logic [LEN_W-1:0]   row_length;
    } packed_word_t;

    localparam int BLOCK_MAX  = 128;
    localparam int RUN_MAX    = 128;
    localparam int RUN_MIN    = 3;
    localparam int STORE_SIZE = BLOCK_MAX + 1;
    localparam int ITEM_CAP   = 17 * WORD_BYTES;
    localparam int DRAIN_WAIT = 200;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                s_row_end = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [WORD_W-1:0]   m_packed_bytes;
    logic [COUNT_W-1:0]  m_byte_count;
    logic                m_last_of_item;
    logic                m_row_done;
    logic [LEN_W-1:0]    m_row_length;

    row_byte_t    pending_bytes[$];
    packed_word_t expected_words[$];
    int           total_bytes = 0;
    int           sent_cnt = 0;
    int           taken_cnt = 0;
    int           tail_from = 0;
    int           err_cnt = 0;
    logic         calm = 1'b0;
    logic         bursts_on;
    int           src_gap = 0;
    int           sink_stall = 0;
    logic [BYTE_W-1:0] gen_prev = '0;

    // Encoder state mirrored by the predictor
    logic [BYTE_W-1:0] lit_mem [0:STORE_SIZE-1];
    logic [FILL_W-1:0] blk_fill = '0;
    logic [BYTE_W-1:0] run_pos = '0;
    logic [BYTE_W-1:0] last_seen = '0;
    logic              repeating = 1'b0;
    logic              row_open = 1'b0;
    logic [LEN_W-1:0]  row_bytes = '0;
    logic [BYTE_W-1:0] item_bytes[$];

    packbits_row_encoder DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_row_end      (s_row_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_bytes (m_packed_bytes),
        .m_byte_count   (m_byte_count),
        .m_last_of_item (m_last_of_item),
        .m_row_done     (m_row_done),
        .m_row_length   (m_row_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Drop idling during calm stretches and for the whole closing row
    assign bursts_on = !calm && (sent_cnt < tail_from);

    // Append one encoded byte; the row length saturates
    function automatic void put_byte(input logic [BYTE_W-1:0] b);
        if (item_bytes.size() < ITEM_CAP)
            item_bytes.push_back(b);
        if (row_bytes != '1)
            row_bytes++;
    endfunction

    // Write a literal block: count byte n-1, then the held bytes
    function automatic void flush_literal(input int n);
        put_byte(BYTE_W'(n - 1));
        for (int i = 0; i < n; i++)
            put_byte(i < STORE_SIZE ? lit_mem[i] : '0);
    endfunction

    // Write a run: header 1-n modulo 256, then the value
    function automatic void flush_run(input int n, input logic [BYTE_W-1:0] v);
        put_byte(BYTE_W'(257 - n));
        put_byte(v);
    endfunction

    function automatic void open_block(input logic [BYTE_W-1:0] c);
        lit_mem[0] = c;
        blk_fill = FILL_W'(1);
        run_pos = '0;
    endfunction

    // Advance the encoder by one byte and queue the words it should produce
    function automatic void encode_byte(input logic [BYTE_W-1:0] c, input logic fin);
        int n;
        int nres;
        int cnt;
        logic [WORD_W-1:0] w;
        packed_word_t pw;
        item_bytes.delete();
        if (!row_open) begin
            open_block(c);
            last_seen = c;
            repeating = 1'b0;
            row_open = 1'b1;
            row_bytes = '0;
        end else begin
            if (blk_fill < STORE_SIZE)
                lit_mem[blk_fill] = c;
            blk_fill = blk_fill + FILL_W'(1);
            n = int'(blk_fill);
            if (!repeating) begin
                if (n > BLOCK_MAX) begin
                    flush_literal(n - 1);
                    open_block(c);
                end else if (c == last_seen) begin
                    if (n - int'(run_pos) >= RUN_MIN) begin
                        if (run_pos != '0)
                            flush_literal(int'(run_pos));
                        repeating = 1'b1;
                    end else if (run_pos == '0) begin
                        repeating = 1'b1;
                    end
                end else begin
                    run_pos = BYTE_W'(n - 1);
                end
            end else if (c != last_seen || n - int'(run_pos) > RUN_MAX) begin
                flush_run(n - 1 - int'(run_pos), last_seen);
                open_block(c);
                repeating = 1'b0;
            end
            last_seen = c;
        end
        // Close the row: write what is held
        if (fin) begin
            if (repeating)
                flush_run(int'(blk_fill) - int'(run_pos), last_seen);
            else
                flush_literal(int'(blk_fill));
            row_open = 1'b0;
            repeating = 1'b0;
            blk_fill = '0;
            run_pos = '0;
            last_seen = '0;
        end
        // Pack eight bytes per word, first byte lowest
        nres = (item_bytes.size() + WORD_BYTES - 1) / WORD_BYTES;
        for (int k = 0; k < nres; k++) begin
            w = '0;
            cnt = 0;
            for (int j = 0; j < WORD_BYTES && k * WORD_BYTES + j < item_bytes.size(); j++) begin
                w |= WORD_W'(item_bytes[k * WORD_BYTES + j]) << (BYTE_W * j);
                cnt++;
            end
            pw.packed_bytes = w;
            pw.byte_count   = COUNT_W'(cnt);
            pw.last_of_item = (k == nres - 1);
            pw.row_done     = (k == nres - 1) && fin;
            pw.row_length   = pw.row_done ? row_bytes : '0;
            expected_words.push_back(pw);
        end
        if (fin)
            row_bytes = '0;
    endfunction

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic last);
        row_byte_t rb;
        rb.data_byte = b;
        rb.row_end = last;
        pending_bytes.push_back(rb);
        gen_prev = b;
    endtask

    // Bytes that never repeat their neighbor
    task automatic add_literal(input int len, input logic close_row);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == gen_prev)
                b = b + BYTE_W'(1);
            add_byte(b, close_row && i == len - 1);
        end
    endtask

    task automatic add_run(input int len, input logic [BYTE_W-1:0] v, input logic close_row);
        for (int i = 0; i < len; i++)
            add_byte(v, close_row && i == len - 1);
    endtask

    // Row of short random runs and literals
    task automatic add_row(input int segs);
        int len;
        for (int s = 0; s < segs; s++) begin
            len = $urandom_range(1, 6);
            if ($urandom_range(0, 1))
                add_run(len, BYTE_W'($urandom_range(0, 255)), s == segs - 1);
            else
                add_literal(len, s == segs - 1);
        end
    endtask

    // Source: present queued requests, with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if ($urandom_range(0, 39) == 0)
                calm <= !calm;
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_row_end);
                taken_cnt <= taken_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (bursts_on && $urandom_range(0, 3) == 0) begin
                    src_gap <= $urandom_range(0, 8);
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    s_data_byte <= pending_bytes[0].data_byte;
                    s_row_end <= pending_bytes[0].row_end;
                    s_valid <= 1'b1;
                    void'(pending_bytes.pop_front());
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Sink: check each accepted word, stall in random bursts
    always @(posedge aclk) begin
        packed_word_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: packed_bytes %h byte_count %0d",
                           m_packed_bytes, m_byte_count);
                    err_cnt++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_packed_bytes !== exp_w.packed_bytes) begin
                        $error("packed_bytes: expected %h, got %h",
                               exp_w.packed_bytes, m_packed_bytes);
                        err_cnt++;
                    end
                    if (m_byte_count !== exp_w.byte_count) begin
                        $error("byte_count: expected %0d, got %0d",
                               exp_w.byte_count, m_byte_count);
                        err_cnt++;
                    end
                    if (m_last_of_item !== exp_w.last_of_item) begin
                        $error("last_of_item: expected %b, got %b",
                               exp_w.last_of_item, m_last_of_item);
                        err_cnt++;
                    end
                    if (m_row_done !== exp_w.row_done) begin
                        $error("row_done: expected %b, got %b", exp_w.row_done, m_row_done);
                        err_cnt++;
                    end
                    if (m_row_length !== exp_w.row_length) begin
                        $error("row_length: expected %0d, got %0d",
                               exp_w.row_length, m_row_length);
                        err_cnt++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall <= sink_stall - 1;
                m_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 3) == 0) begin
                sink_stall <= $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Build the request list, release reset, wait for the drain
    initial begin
        tail_from = 1 << 30;
        // One-byte rows at both byte extremes
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // Pair at block start turns into a run of two
        add_run(2, 8'h55, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        // Literal closed by a run of three
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_run(3, 8'h03, 1'b1);
        // Run ended by a different byte
        add_run(3, 8'h7F, 1'b0);
        add_byte(8'h80, 1'b1);
        // Pair inside a literal stays literal
        add_byte(8'h10, 1'b0);
        add_run(2, 8'h20, 1'b0);
        add_byte(8'h30, 1'b1);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b1);
        // Random rows
        while (pending_bytes.size() < 80)
            add_row($urandom_range(1, 4));
        // Closing row, sent without idling
        tail_from = pending_bytes.size();
        add_literal(5, 1'b0);
        add_run(4, 8'hC3, 1'b0);
        add_literal(3, 1'b1);
        total_bytes = pending_bytes.size();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (taken_cnt < total_bytes || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case the encoder hangs
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
